### hw/rtl/utpg_pkg.sv
// Shared types and constants for the tick-driven UART transceiver with parity and gap timer.
// No dependencies; every module of the block imports this package.
package utpg_pkg;

   localparam int unsigned BitTicksW = 16;
   localparam int unsigned TxCountW  = BitTicksW + 1;
   localparam int unsigned GapW      = 24;
   localparam int unsigned ByteW     = 8;
   localparam int unsigned CsrIndexW = 3;
   localparam int unsigned CsrDataW  = GapW;
   localparam int unsigned BitIdxW   = 4;

   localparam logic [BitTicksW-1:0] BitTicksMin   = 16'd4;
   localparam logic [BitTicksW-1:0] BitTicksReset = 16'd139;
   localparam logic [1:0]           StopBitsReset = 2'd1;
   localparam logic [GapW-1:0]      GapCountMax   = 24'hFF_FFFF;
   localparam logic [BitIdxW-1:0]   DataBits      = 4'd8;

   typedef enum logic [CsrIndexW-1:0] {
      REG_BIT_TICKS   = 3'd0,
      REG_INVERT_LINE = 3'd1,
      REG_PARITY_MODE = 3'd2,
      REG_STOP_BITS   = 3'd3,
      REG_GAP_TICKS   = 3'd4,
      REG_HALF_DUPLEX = 3'd5
   } csr_index_type;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_START  = 5'b00010,
      PH_DATA   = 5'b00100,
      PH_PARITY = 5'b01000,
      PH_STOP   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [BitTicksW-1:0] bit_ticks;
      logic                 invert_line;
      logic [1:0]           parity_mode;
      logic [1:0]           stop_bits;
      logic [GapW-1:0]      gap_ticks;
      logic                 half_duplex;
   } cfg_type;

   typedef struct packed {
      logic tx_line;
      logic tx_busy;
   } tx_status_type;

   typedef struct packed {
      logic             rx_valid;
      logic [ByteW-1:0] rx_byte;
      logic             rx_after_gap;
      logic             gap_elapsed;
   } rx_result_type;

   // Bit period clamped to the minimum supported length.
   function automatic logic [BitTicksW-1:0] eff_bit_ticks(input logic [BitTicksW-1:0] bt);
      return (bt < BitTicksMin) ? BitTicksMin : bt;
   endfunction

endpackage

### hw/rtl/utpg_csr.sv
// Configuration registers of the UART transceiver, written through a plain write port.
// Depends on utpg_pkg.
module utpg_csr import utpg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            REG_BIT_TICKS:   cfg_in.bit_ticks   = csr_wr_data[BitTicksW-1:0];
            REG_INVERT_LINE: cfg_in.invert_line = csr_wr_data[0];
            REG_PARITY_MODE: cfg_in.parity_mode = csr_wr_data[1:0];
            REG_STOP_BITS:   cfg_in.stop_bits   = csr_wr_data[1:0];
            REG_GAP_TICKS:   cfg_in.gap_ticks   = csr_wr_data[GapW-1:0];
            REG_HALF_DUPLEX: cfg_in.half_duplex = csr_wr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_ticks   <= BitTicksReset;
         cfg_ff.invert_line <= 1'b0;
         cfg_ff.parity_mode <= 2'd0;
         cfg_ff.stop_bits   <= StopBitsReset;
         cfg_ff.gap_ticks   <= '0;
         cfg_ff.half_duplex <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/utpg_tx.sv
// Transmit framer: start bit, eight data bits LSB first, optional parity, one or two stops.
// Depends on utpg_pkg; state advances one tick per step.
module utpg_tx import utpg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             tx_start,
   input  logic [ByteW-1:0] tx_byte,
   input  cfg_type          cfg,
   output tx_status_type    status
);

   phase_type             phase_ff, phase_in, phase_eff;
   logic [TxCountW-1:0]   cnt_ff, cnt_in, cnt_eff, cnt_inc, len;
   logic [ByteW-1:0]      shift_ff, shift_in, shift_eff;
   logic [BitIdxW-1:0]    idx_ff, idx_in, idx_eff, idx_inc;
   logic                  acc_ff, acc_in, acc_eff;
   logic [BitTicksW-1:0]  bt;
   logic                  busy;
   logic                  level;

   always_comb begin
      bt        = eff_bit_ticks(cfg.bit_ticks);
      phase_eff = phase_ff;
      cnt_eff   = cnt_ff;
      shift_eff = shift_ff;
      idx_eff   = idx_ff;
      acc_eff   = acc_ff;
      // a request in idle puts the start bit out in the same tick
      if (phase_ff == PH_IDLE && tx_start) begin
         phase_eff = PH_START;
         cnt_eff   = '0;
         shift_eff = tx_byte;
         idx_eff   = '0;
         acc_eff   = 1'b0;
      end
      busy = (phase_eff != PH_IDLE);

      unique case (phase_eff)
         PH_START:  level = 1'b0;
         PH_DATA:   level = shift_eff[0];
         PH_PARITY: level = acc_eff ^ cfg.parity_mode[0];
         default:   level = 1'b1;
      endcase

      // stop_bits 2 or 3 mean two stop periods
      len     = (phase_eff == PH_STOP && cfg.stop_bits[1]) ? {bt, 1'b0} : {1'b0, bt};
      cnt_inc = cnt_eff + 1'b1;
      idx_inc = idx_eff + 1'b1;

      phase_in = phase_eff;
      cnt_in   = cnt_eff;
      shift_in = shift_eff;
      idx_in   = idx_eff;
      acc_in   = acc_eff;
      if (busy) begin
         cnt_in = cnt_inc;
         if (cnt_inc >= len) begin
            cnt_in = '0;
            unique case (phase_eff)
               PH_START: begin
                  phase_in = PH_DATA;
                  idx_in   = '0;
               end
               PH_DATA: begin
                  acc_in   = acc_eff ^ shift_eff[0];
                  shift_in = {1'b0, shift_eff[ByteW-1:1]};
                  idx_in   = idx_inc;
                  if (idx_inc >= DataBits) begin
                     phase_in = (cfg.parity_mode != 2'd0) ? PH_PARITY : PH_STOP;
                  end
               end
               PH_PARITY: phase_in = PH_STOP;
               default:   phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         shift_ff <= '0;
         idx_ff   <= '0;
         acc_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         shift_ff <= shift_in;
         idx_ff   <= idx_in;
         acc_ff   <= acc_in;
      end
   end

   assign status.tx_line = level ^ cfg.invert_line;
   assign status.tx_busy = busy;

endmodule

### hw/rtl/utpg_rx.sv
// Receive deframer with mid-bit sampling, parity skip and the inter-byte gap timer.
// Depends on utpg_pkg; state advances one tick per step.
module utpg_rx import utpg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic          rx_line,
   input  logic          tx_busy,
   input  cfg_type       cfg,
   output rx_result_type result
);

   phase_type            phase_ff, phase_in;
   logic [BitTicksW-1:0] cnt_ff, cnt_in, cnt_inc;
   logic [ByteW-1:0]     shift_ff, shift_in;
   logic [BitIdxW-1:0]   idx_ff, idx_in, idx_inc;
   logic                 last_ff;
   logic [GapW-1:0]      gap_cnt_ff, gap_cnt_in;
   logic                 gap_flag_ff, gap_flag_in;
   logic                 gap_armed_ff, gap_armed_in;
   logic [BitTicksW-1:0] bt;
   logic                 inv;
   logic                 done;
   logic                 after;

   always_comb begin
      bt  = eff_bit_ticks(cfg.bit_ticks);
      inv = cfg.invert_line;

      // gap timer runs first so a byte completing now sees this tick's flag
      gap_cnt_in   = gap_cnt_ff;
      gap_flag_in  = gap_flag_ff;
      gap_armed_in = gap_armed_ff;
      if (gap_armed_ff && cfg.gap_ticks != '0) begin
         if (gap_cnt_ff < GapCountMax) begin
            gap_cnt_in = gap_cnt_ff + 1'b1;
         end
         if (gap_cnt_in >= cfg.gap_ticks) begin
            gap_flag_in  = 1'b1;
            gap_armed_in = 1'b0;
         end
      end

      cnt_inc  = cnt_ff + 1'b1;
      idx_inc  = idx_ff + 1'b1;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      idx_in   = idx_ff;
      done     = 1'b0;
      after    = 1'b0;

      priority if (cfg.half_duplex && tx_busy) begin
         // drop any reception while our own frame is on the wire
         phase_in = PH_IDLE;
         cnt_in   = '0;
      end else if (phase_ff == PH_IDLE) begin
         if (rx_line == inv && last_ff != inv) begin
            phase_in = PH_START;
            cnt_in   = '0;
            shift_in = '0;
            idx_in   = '0;
         end
      end else begin
         cnt_in = cnt_inc;
         unique case (phase_ff)
            PH_START: begin
               if (cnt_inc >= {1'b0, bt[BitTicksW-1:1]}) begin
                  phase_in = PH_DATA;
                  cnt_in   = '0;
               end
            end
            PH_DATA: begin
               if (cnt_inc >= bt) begin
                  cnt_in   = '0;
                  shift_in = {rx_line, shift_ff[ByteW-1:1]};
                  idx_in   = idx_inc;
                  if (idx_inc >= DataBits) begin
                     if (cfg.parity_mode != 2'd0) begin
                        phase_in = PH_PARITY;
                     end else begin
                        done = 1'b1;
                     end
                  end
               end
            end
            default: begin
               // parity bit is skipped unchecked
               if (cnt_inc >= bt) begin
                  done = 1'b1;
               end
            end
         endcase
      end

      if (done) begin
         after        = gap_flag_in;
         gap_flag_in  = 1'b0;
         gap_cnt_in   = '0;
         gap_armed_in = 1'b1;
         phase_in     = PH_IDLE;
         cnt_in       = '0;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         shift_ff     <= '0;
         idx_ff       <= '0;
         last_ff      <= 1'b1;
         gap_cnt_ff   <= '0;
         gap_flag_ff  <= 1'b0;
         gap_armed_ff <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         shift_ff     <= shift_in;
         idx_ff       <= idx_in;
         last_ff      <= rx_line;
         gap_cnt_ff   <= gap_cnt_in;
         gap_flag_ff  <= gap_flag_in;
         gap_armed_ff <= gap_armed_in;
      end
   end

   assign result.rx_valid     = done;
   assign result.rx_byte      = done ? (shift_in ^ {ByteW{inv}}) : '0;
   assign result.rx_after_gap = after;
   assign result.gap_elapsed  = gap_flag_in;

endmodule

### hw/rtl/uart_transceiver_parity_gap_core.sv
// Top level of the tick-driven UART transceiver with parity and receive gap timer.
// Depends on utpg_pkg, utpg_csr, utpg_tx and utpg_rx.
//
// Usage:
//   Each request item is one line tick: the sampled receive level plus an
//   optional transmit request with its byte. Each item yields exactly one
//   response item carrying the transmit line, driver enable, busy flag and
//   any byte that completed reception on that tick.
//   An accepted item lands in an input register; when it advances, the framer
//   and deframer update their state and the response register loads, so a
//   response is offered from the response register behind the input register.
//   Throughput is one item per cycle while the response side does not
//   stall, set by the single combinational update between the two registers.
//   When the response side stalls, the response register holds; one more
//   item is still taken into the input register, then req_stall rises
//   until the response is taken.
//   Reset restores all configuration registers to their defaults, returns
//   both framers to idle with the receive line history at idle level and
//   disarms the gap timer. Write the csr_ port only while no items are in
//   flight.
module uart_transceiver_parity_gap_core import utpg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_rx_line,
   input  logic                 req_tx_start,
   input  logic [ByteW-1:0]     req_tx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_tx_line,
   output logic                 rsp_tx_drive,
   output logic                 rsp_tx_busy,
   output logic                 rsp_rx_valid,
   output logic [ByteW-1:0]     rsp_rx_byte,
   output logic                 rsp_rx_after_gap,
   output logic                 rsp_gap_elapsed,
   input  logic                 csr_wr_en,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wr_data
);

   cfg_type          cfg;
   tx_status_type    tx_status;
   rx_result_type    rx_result;

   logic             in_valid_ff, in_valid_in;
   logic             in_line_ff;
   logic             in_start_ff;
   logic [ByteW-1:0] in_byte_ff;
   logic             out_valid_ff, out_valid_in;
   logic             out_line_ff, out_drive_ff, out_busy_ff;
   logic             out_rx_valid_ff, out_after_ff, out_gap_ff;
   logic [ByteW-1:0] out_rx_byte_ff;
   logic             advance;
   logic             take;

   // advance the held item whenever the response slot is free or emptying
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_line_ff  <= req_rx_line;
         in_start_ff <= req_tx_start;
         in_byte_ff  <= req_tx_byte;
      end
      if (advance) begin
         out_line_ff     <= tx_status.tx_line;
         out_drive_ff    <= cfg.half_duplex ? tx_status.tx_busy : 1'b1;
         out_busy_ff     <= tx_status.tx_busy;
         out_rx_valid_ff <= rx_result.rx_valid;
         out_rx_byte_ff  <= rx_result.rx_byte;
         out_after_ff    <= rx_result.rx_after_gap;
         out_gap_ff      <= rx_result.gap_elapsed;
      end
   end

   utpg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   utpg_tx u_tx (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .tx_start (in_start_ff),
      .tx_byte  (in_byte_ff),
      .cfg      (cfg),
      .status   (tx_status)
   );

   utpg_rx u_rx (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_line (in_line_ff),
      .tx_busy (tx_status.tx_busy),
      .cfg     (cfg),
      .result  (rx_result)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_tx_line      = out_line_ff;
   assign rsp_tx_drive     = out_drive_ff;
   assign rsp_tx_busy      = out_busy_ff;
   assign rsp_rx_valid     = out_rx_valid_ff;
   assign rsp_rx_byte      = out_rx_byte_ff;
   assign rsp_rx_after_gap = out_after_ff;
   assign rsp_gap_elapsed  = out_gap_ff;

endmodule
